// ===== rtl/core/pcm_pkg.sv =====
// Shared types, constants and helper functions for the particle cloud moments block.
package pcm_pkg;

   // Capacity of one cloud and the widths that follow from it.
   localparam int MAX_PARTICLES_LOG2 = 20;
   localparam int CNT_W = MAX_PARTICLES_LOG2 + 1;
   localparam int DIV_W = (CNT_W + 16 > 36) ? CNT_W + 16 : 36;

   // Output field limits.
   localparam logic [63:0] MASS_MAX      = 64'h0000_000F_FFFF_FFFF;
   localparam logic [63:0] COUNT_OUT_MAX = 64'h0000_0000_001F_FFFF;

   // Divider quotient register width and the moment limits.
   localparam int QUO_W = 58;
   localparam logic [QUO_W-1:0] LIM_FIRST  = QUO_W'(64'd1 << 23);
   localparam logic [QUO_W-1:0] LIM_SECOND = QUO_W'(64'd1 << 47);
   localparam logic [QUO_W-1:0] LIM_THIRD  = QUO_W'(64'd1 << 55);

   // Configuration register indexes.
   localparam logic [1:0] CSR_WEIGHTED_MODE     = 2'd0;
   localparam logic [1:0] CSR_MASS_PER_PARTICLE = 2'd1;

   // Axis and moment selectors.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;
   localparam logic [1:0] MOM_FIRST  = 2'd0;
   localparam logic [1:0] MOM_SECOND = 2'd1;
   localparam logic [1:0] MOM_THIRD  = 2'd2;

   // Controller states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_ACC,
      S_DIV_GO,
      S_DIV_WAIT,
      S_FIN1,
      S_FIN2,
      S_FIN3,
      S_FIN4,
      S_OUT
   } state_type;

   // Datapath operations.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL1,
      OP_MUL2,
      OP_MUL3,
      OP_ACC,
      OP_DIV_GO,
      OP_DIV_SAVE,
      OP_FIN1,
      OP_FIN2,
      OP_FIN3,
      OP_FIN4,
      OP_OUT
   } op_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      op_type     op;
      logic [1:0] axis;
      logic [1:0] mom;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;
      logic div_done;
      logic out_free;
   } stat_type;

   // Signed 64-bit add that saturates at either end.
   function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                  logic signed [63:0] b);
      logic signed [64:0] s;
      logic signed [63:0] r;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         r = s[63:0];
      end
      return r;
   endfunction

   // Number of dividend bits below the binary point for each moment.
   function automatic logic [5:0] frac_bits(logic [1:0] mom);
      logic [5:0] n;
      case (mom)
         MOM_FIRST:  n = 6'd9;
         MOM_SECOND: n = 6'd25;
         default:    n = 6'd33;
      endcase
      return n;
   endfunction

   // Saturation limit of each moment.
   function automatic logic [QUO_W-1:0] mom_limit(logic [1:0] mom);
      logic [QUO_W-1:0] l;
      case (mom)
         MOM_FIRST:  l = LIM_FIRST;
         MOM_SECOND: l = LIM_SECOND;
         default:    l = LIM_THIRD;
      endcase
      return l;
   endfunction

endpackage

// ===== rtl/core/pcm_div.sv =====
// Restoring bit-serial divider producing a scaled quotient with an overflow flag.
module pcm_div
   import pcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [63:0]        mag,
   input  logic [5:0]         nbits,
   input  logic [DIV_W-1:0]   dvs,
   output logic               done,
   output logic [QUO_W-1:0]   quo,
   output logic               ovf
);

   logic             running_ff, running_in;
   logic             done_ff, done_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic [6:0]       len_ff, len_in;
   logic [63:0]      dvd_ff, dvd_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic             ovf_ff, ovf_in;
   logic [DIV_W:0]   trial;
   logic             ge;

   // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
   always_comb begin
      trial = {rem_ff, dvd_ff[63]};
      ge    = (trial >= {1'b0, dvs});
      running_in = running_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      len_in     = len_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      ovf_in     = ovf_ff;
      if (start) begin
         running_in = 1'b1;
         cnt_in     = 7'd0;
         len_in     = 7'd64 + 7'(nbits);
         dvd_in     = mag;
         rem_in     = '0;
         quo_in     = '0;
         ovf_in     = 1'b0;
      end else if (running_ff) begin
         dvd_in = {dvd_ff[62:0], 1'b0};
         rem_in = ge ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
         ovf_in = ovf_ff | quo_ff[QUO_W-1];
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == len_ff - 7'd1) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      len_ff <= len_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign ovf  = ovf_ff;

endmodule

// ===== rtl/core/pcm_dp.sv =====
// Datapath: configuration, per-axis accumulators, moment division and result register.
module pcm_dp
   import pcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_pos_z,
   input  logic [15:0]        req_particle_mass,
   input  logic               req_last_particle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_axis,
   output logic signed [15:0] rsp_mean,
   output logic [31:0]        rsp_variance,
   output logic signed [47:0] rsp_third_moment,
   output logic [20:0]        rsp_particle_count,
   output logic [35:0]        rsp_total_mass,
   output logic               rsp_last_result,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   // Configuration registers.
   logic        weighted_ff;
   logic [15:0] mpp_ff;

   // Captured particle.
   logic signed [15:0] pos_ff [3];
   logic [15:0]        pm_ff;
   logic [16:0]        w_ff;
   logic               last_ff;
   logic               take_ff;

   // Product pipeline registers, one lane per axis.
   logic [30:0]        sq1_ff [3];
   logic signed [33:0] pw_ff  [3];
   logic [47:0]        p2w_ff [3];
   logic signed [46:0] p3_ff  [3];
   logic signed [41:0] phi_ff [3];
   logic [39:0]        plo_ff [3];

   // Accumulators.
   logic [CNT_W-1:0]   count_ff;
   logic [35:0]        mass_ff;
   logic signed [63:0] first_ff  [3];
   logic signed [63:0] second_ff [3];
   logic signed [63:0] third_ff  [3];

   // Moments and finishing registers.
   logic signed [24:0] m1_ff;
   logic [47:0]        m2_ff;
   logic signed [56:0] m3_ff;
   logic [46:0]        sqm_ff;
   logic signed [15:0] mean_ff, mean_in;
   logic [31:0]        var_ff, var_in;
   logic signed [34:0] rt_ff, rt_in;
   logic signed [59:0] prod_ff;
   logic signed [47:0] th_ff, th_in;

   // Result register.
   logic               rsp_valid_ff;
   logic [1:0]         rsp_axis_ff;
   logic signed [15:0] rsp_mean_ff;
   logic [31:0]        rsp_var_ff;
   logic signed [47:0] rsp_third_ff;
   logic [20:0]        rsp_count_ff;
   logic [35:0]        rsp_mass_ff;
   logic               rsp_last_ff;

   // Combinational helpers.
   logic signed [17:0] w_s;
   logic signed [31:0] sq_full  [3];
   logic signed [33:0] pw_full  [3];
   logic [47:0]        p2w_full [3];
   logic signed [46:0] p3_full  [3];
   logic signed [41:0] phi_full [3];
   logic [39:0]        plo_full [3];
   logic signed [63:0] p3w      [3];
   logic signed [63:0] term1    [3];
   logic signed [63:0] term2    [3];
   logic signed [63:0] term3    [3];
   logic [36:0]        mass_sum;
   logic               csr_wr;

   logic signed [63:0] sum_sel;
   logic               sum_neg;
   logic [63:0]        div_mag;
   logic [DIV_W-1:0]   wsum;
   logic               wzero;
   logic               div_done;
   logic [QUO_W-1:0]   div_quo;
   logic               div_ovf;
   logic [QUO_W:0]     quo_inc;
   logic [QUO_W-1:0]   quo_rnd;
   logic [QUO_W-1:0]   lim;
   logic [55:0]        res_mag;
   logic signed [56:0] res_sgn;

   logic signed [49:0] m1sq_full;
   logic [24:0]        m1_mag;
   logic [24:0]        m1_rnd_t;
   logic [16:0]        m1_rnd;
   logic signed [48:0] v_full;
   logic [48:0]        v_rnd_t;
   logic [32:0]        v_rnd;
   logic signed [50:0] t_full;
   logic [50:0]        t_mag;
   logic [51:0]        t_rnd_t;
   logic [35:0]        t_rnd;
   logic signed [59:0] prod_full;
   logic signed [60:0] th_full;
   logic [60:0]        th_mag;
   logic [61:0]        th_rnd_t;
   logic [53:0]        th_rnd;
   logic [CNT_W+15:0]  tm_full;
   logic [35:0]        tmass;
   logic [20:0]        count_out;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         weighted_ff <= 1'b0;
         mpp_ff      <= 16'hFFFF;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_WEIGHTED_MODE:     weighted_ff <= csr_wdata[0];
            CSR_MASS_PER_PARTICLE: mpp_ff      <= csr_wdata;
            default:               ;
         endcase
      end
   end

   // Per-lane products and accumulation terms.
   always_comb begin
      w_s = $signed({1'b0, w_ff});
      for (int a = 0; a < 3; a++) begin
         sq_full[a]  = pos_ff[a] * pos_ff[a];
         pw_full[a]  = pos_ff[a] * w_s;
         p2w_full[a] = sq1_ff[a] * w_ff;
         p3_full[a]  = $signed({1'b0, sq1_ff[a]}) * pos_ff[a];
         phi_full[a] = $signed(p3_ff[a][46:23]) * w_s;
         plo_full[a] = p3_ff[a][22:0] * w_ff;
         p3w[a]      = ($signed({{22{phi_ff[a][41]}}, phi_ff[a]}) <<< 23)
                       + $signed({24'd0, plo_ff[a]});
         term1[a]    = $signed({{30{pw_ff[a][33]}}, pw_ff[a]});
         term2[a]    = $signed({24'd0, p2w_ff[a][47:8]});
         term3[a]    = p3w[a] >>> 24;
      end
      mass_sum = {1'b0, mass_ff} + 37'(pm_ff);
   end

   // Particle capture and product pipeline.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            pos_ff[0] <= req_pos_x;
            pos_ff[1] <= req_pos_y;
            pos_ff[2] <= req_pos_z;
            pm_ff     <= req_particle_mass;
            w_ff      <= weighted_ff ? {1'b0, req_particle_mass} : 17'h10000;
         end
         OP_MUL1: begin
            for (int a = 0; a < 3; a++) begin
               sq1_ff[a] <= sq_full[a][30:0];
               pw_ff[a]  <= pw_full[a];
            end
         end
         OP_MUL2: begin
            for (int a = 0; a < 3; a++) begin
               p2w_ff[a] <= p2w_full[a];
               p3_ff[a]  <= p3_full[a];
            end
         end
         OP_MUL3: begin
            for (int a = 0; a < 3; a++) begin
               phi_ff[a] <= phi_full[a];
               plo_ff[a] <= plo_full[a];
            end
         end
         default: ;
      endcase
   end

   // Last flag and capacity check taken with the beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b0;
         take_ff <= 1'b0;
      end else if (cmd.op == OP_LOAD) begin
         last_ff <= req_last_particle;
         take_ff <= ~count_ff[CNT_W-1];
      end
   end

   // Accumulators: added on a taken particle, cleared after the z result.
   always_ff @(posedge clock) begin
      if (reset || (cmd.op == OP_OUT && cmd.axis == AXIS_Z)) begin
         count_ff <= '0;
         mass_ff  <= '0;
         for (int a = 0; a < 3; a++) begin
            first_ff[a]  <= '0;
            second_ff[a] <= '0;
            third_ff[a]  <= '0;
         end
      end else if (cmd.op == OP_ACC && take_ff) begin
         count_ff <= count_ff + CNT_W'(1);
         mass_ff  <= mass_sum[36] ? {36{1'b1}} : mass_sum[35:0];
         for (int a = 0; a < 3; a++) begin
            first_ff[a]  <= sat_add(first_ff[a], term1[a]);
            second_ff[a] <= sat_add(second_ff[a], term2[a]);
            third_ff[a]  <= sat_add(third_ff[a], term3[a]);
         end
      end
   end

   // Select the sum to divide and the divisor.
   always_comb begin
      case (cmd.axis)
         AXIS_X: begin
            case (cmd.mom)
               MOM_FIRST:  sum_sel = first_ff[0];
               MOM_SECOND: sum_sel = second_ff[0];
               default:    sum_sel = third_ff[0];
            endcase
         end
         AXIS_Y: begin
            case (cmd.mom)
               MOM_FIRST:  sum_sel = first_ff[1];
               MOM_SECOND: sum_sel = second_ff[1];
               default:    sum_sel = third_ff[1];
            endcase
         end
         default: begin
            case (cmd.mom)
               MOM_FIRST:  sum_sel = first_ff[2];
               MOM_SECOND: sum_sel = second_ff[2];
               default:    sum_sel = third_ff[2];
            endcase
         end
      endcase
      sum_neg = sum_sel[63];
      div_mag = sum_neg ? 64'(-sum_sel) : 64'(sum_sel);
      wsum    = weighted_ff ? DIV_W'(mass_ff) : DIV_W'({count_ff, 16'd0});
      wzero   = (wsum == '0);
   end

   pcm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == OP_DIV_GO),
      .mag   (div_mag),
      .nbits (frac_bits(cmd.mom)),
      .dvs   (wsum),
      .done  (div_done),
      .quo   (div_quo),
      .ovf   (div_ovf)
   );

   // Round half up the doubled quotient and clamp to the moment limit.
   always_comb begin
      lim     = mom_limit(cmd.mom);
      quo_inc = {1'b0, div_quo} + (QUO_W+1)'(1);
      quo_rnd = quo_inc[QUO_W:1];
      res_mag = (div_ovf || quo_rnd > lim) ? lim[55:0] : quo_rnd[55:0];
      res_sgn = sum_neg ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
   end

   // Store each moment as it completes.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_DIV_SAVE) begin
         case (cmd.mom)
            MOM_FIRST:  m1_ff <= res_sgn[24:0];
            MOM_SECOND: m2_ff <= res_mag[47:0];
            default:    m3_ff <= res_sgn;
         endcase
      end
   end

   // Finishing arithmetic: mean, variance and third central moment.
   always_comb begin
      m1sq_full = m1_ff * m1_ff;
      m1_mag    = m1_ff[24] ? 25'(-m1_ff) : 25'(m1_ff);
      m1_rnd_t  = m1_mag + 25'd128;
      m1_rnd    = m1_rnd_t[24:8];
      if (m1_ff[24]) begin
         mean_in = (m1_rnd > 17'd32768) ? 16'sh8000 : 16'(17'd0 - m1_rnd);
      end else begin
         mean_in = (m1_rnd > 17'd32767) ? 16'sh7FFF : m1_rnd[15:0];
      end

      v_full  = $signed({1'b0, m2_ff}) - $signed({2'b0, sqm_ff});
      v_rnd_t = {1'b0, v_full[47:0]} + 49'h8000;
      v_rnd   = v_rnd_t[48:16];
      if (v_full[48]) begin
         var_in = '0;
      end else begin
         var_in = v_rnd[32] ? 32'hFFFF_FFFF : v_rnd[31:0];
      end

      t_full  = $signed({3'b0, m2_ff}) + $signed({2'b0, m2_ff, 1'b0})
                - $signed({3'b0, sqm_ff, 1'b0});
      t_mag   = t_full[50] ? 51'(-t_full) : 51'(t_full);
      t_rnd_t = {1'b0, t_mag} + 52'h8000;
      t_rnd   = t_rnd_t[51:16];
      rt_in   = 35'(t_full[50] ? (36'd0 - t_rnd) : t_rnd);

      prod_full = rt_ff * m1_ff;

      th_full  = $signed({{4{m3_ff[56]}}, m3_ff}) - $signed({prod_ff[59], prod_ff});
      th_mag   = th_full[60] ? 61'(-th_full) : 61'(th_full);
      th_rnd_t = {1'b0, th_mag} + 62'd128;
      th_rnd   = th_rnd_t[61:8];
      if (th_full[60]) begin
         th_in = (th_rnd > (54'd1 << 47)) ? {1'b1, 47'd0} : 48'(54'd0 - th_rnd);
      end else begin
         th_in = (th_rnd > ((54'd1 << 47) - 54'd1)) ? {1'b0, {47{1'b1}}} : th_rnd[47:0];
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_FIN1: begin
            sqm_ff  <= m1sq_full[46:0];
            mean_ff <= mean_in;
         end
         OP_FIN2: begin
            var_ff <= var_in;
            rt_ff  <= rt_in;
         end
         OP_FIN3: prod_ff <= prod_full;
         OP_FIN4: th_ff   <= th_in;
         default: ;
      endcase
   end

   // Count and total mass reported with every result.
   always_comb begin
      tm_full   = count_ff * mpp_ff;
      tmass     = weighted_ff ? mass_ff
                : ((64'(tm_full) > MASS_MAX) ? 36'hF_FFFF_FFFF : 36'(tm_full));
      count_out = (64'(count_ff) > COUNT_OUT_MAX) ? 21'h1F_FFFF : 21'(count_ff);
   end

   // Result register: a beat waits here while the next particle may enter.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_OUT) begin
         rsp_axis_ff  <= cmd.axis;
         rsp_mean_ff  <= wzero ? '0 : mean_ff;
         rsp_var_ff   <= wzero ? '0 : var_ff;
         rsp_third_ff <= wzero ? '0 : th_ff;
         rsp_count_ff <= count_out;
         rsp_mass_ff  <= tmass;
         rsp_last_ff  <= (cmd.axis == AXIS_Z);
      end
   end

   assign stat.last     = last_ff;
   assign stat.div_done = div_done;
   assign stat.out_free = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_axis           = rsp_axis_ff;
   assign rsp_mean           = rsp_mean_ff;
   assign rsp_variance       = rsp_var_ff;
   assign rsp_third_moment   = rsp_third_ff;
   assign rsp_particle_count = rsp_count_ff;
   assign rsp_total_mass     = rsp_mass_ff;
   assign rsp_last_result    = rsp_last_ff;

endmodule

// ===== rtl/core/pcm_ctrl.sv =====
// Controller state machine sequencing accumulation, division and result beats.
module pcm_ctrl
   import pcm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [1:0] mom_ff, mom_in;

   // State and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= AXIS_X;
         mom_ff   <= MOM_FIRST;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         mom_ff   <= mom_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      mom_in   = mom_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_MUL1;
         end
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_MUL3;
         S_MUL3: state_in = S_ACC;
         S_ACC: begin
            if (stat.last) begin
               state_in = S_DIV_GO;
               axis_in  = AXIS_X;
               mom_in   = MOM_FIRST;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV_GO: state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (stat.div_done) begin
               if (mom_ff == MOM_THIRD) begin
                  state_in = S_FIN1;
               end else begin
                  mom_in   = mom_ff + 2'd1;
                  state_in = S_DIV_GO;
               end
            end
         end
         S_FIN1: state_in = S_FIN2;
         S_FIN2: state_in = S_FIN3;
         S_FIN3: state_in = S_FIN4;
         S_FIN4: state_in = S_OUT;
         S_OUT: begin
            if (stat.out_free) begin
               if (axis_ff == AXIS_Z) begin
                  state_in = S_IDLE;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  mom_in   = MOM_FIRST;
                  state_in = S_DIV_GO;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      cmd.axis  = axis_ff;
      cmd.mom   = mom_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         S_MUL1:     cmd.op = OP_MUL1;
         S_MUL2:     cmd.op = OP_MUL2;
         S_MUL3:     cmd.op = OP_MUL3;
         S_ACC:      cmd.op = OP_ACC;
         S_DIV_GO:   cmd.op = OP_DIV_GO;
         S_DIV_WAIT: cmd.op = stat.div_done ? OP_DIV_SAVE : OP_NONE;
         S_FIN1:     cmd.op = OP_FIN1;
         S_FIN2:     cmd.op = OP_FIN2;
         S_FIN3:     cmd.op = OP_FIN3;
         S_FIN4:     cmd.op = OP_FIN4;
         S_OUT:      cmd.op = stat.out_free ? OP_OUT : OP_NONE;
         default:    cmd.op = OP_NONE;
      endcase
   end

endmodule

// ===== rtl/core/particle_cloud_moments_top.sv =====
// Top level of the particle cloud moments block: controller and datapath.
//
//   Channel | Direction | Handshake          | Payload
//   req     | in        | req_valid/ready    | pos_x, pos_y, pos_z, particle_mass, last_particle
//   rsp     | out       | rsp_valid/ready    | axis, mean, variance, third_moment, count, mass, last
//   csr     | in        | csr_valid/ready    | csr_index, csr_wdata
//
// A particle passes the accept beat and four steps through the product lanes.
// A last particle adds the division of three moments per axis on the bit-serial divider
// and the finishing arithmetic for mean, variance and third moment before each axis result.
// Reset is synchronous; it clears the sums and restores the configuration defaults.
// A stalled result beat holds in the output register and holds the controller before the
// next beat; after the z beat the next particle is taken meanwhile.
module particle_cloud_moments_top
   import pcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_pos_z,
   input  logic [15:0]        req_particle_mass,
   input  logic               req_last_particle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_axis,
   output logic signed [15:0] rsp_mean,
   output logic [31:0]        rsp_variance,
   output logic signed [47:0] rsp_third_moment,
   output logic [20:0]        rsp_particle_count,
   output logic [35:0]        rsp_total_mass,
   output logic               rsp_last_result,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   pcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pcm_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .req_particle_mass  (req_particle_mass),
      .req_last_particle  (req_last_particle),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_axis           (rsp_axis),
      .rsp_mean           (rsp_mean),
      .rsp_variance       (rsp_variance),
      .rsp_third_moment   (rsp_third_moment),
      .rsp_particle_count (rsp_particle_count),
      .rsp_total_mass     (rsp_total_mass),
      .rsp_last_result    (rsp_last_result),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

endmodule
